@@ src/rwss_pkg.sv @@
package rwss_pkg;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_PLAY = 2'd1;
	localparam logic [1:0] MODE_ROW  = 2'd2;
	localparam logic [1:0] MODE_EFF  = 2'd3;

	localparam logic [7:0] END_MARK = 8'hFF;
	localparam int MAX_OUT = 64;
	localparam int N_W = $clog2(MAX_OUT + 1);

	typedef struct packed {
		logic [1:0] mode;
		logic [3:0] effect_id;
		logic [5:0] row_index;
		logic [7:0] row_delay;
		logic [7:0] row_register;
		logic [7:0] row_data;
		logic [5:0] effect_start;
		logic       effect_channel;
	} in_t;

	typedef struct packed {
		logic       out_channel;
		logic [7:0] write_address;
		logic [7:0] write_data;
		logic       last_write;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLAY_EFF,
		ST_PLAY_ROW,
		ST_TICK_CH,
		ST_BURST,
		ST_TICK_END
	} state_t;

endpackage

@@ src/register_write_script_sequencer.sv @@
// Register-write script player with independent channels.
// The cmd channel takes one item per handshake: a tick, a play request, a
// script row load or an effect entry load. A load is written as it is taken.
// A play reads the effect entry and then the first script row from their
// memories before the next item is taken.
// A tick visits each channel in turn, and a channel that fires reads its
// script rows one per cycle from the row memory while the wr channel does
// not stall, until a row delay, the end marker, a cap or the last row stops it.
// Each register write leaves on the wr channel as one item; the last item of a
// tick has last_write set. The write is held back one step so that the last
// one can be flagged, and an output register lets the next cmd item be taken
// while the final write still waits.
// When the receiver stalls, the burst pauses on the current row and resumes
// when the output register drains; nothing is dropped.
// Reset leaves every channel idle. The script and effect memories are not
// cleared and must be loaded before they are played.
module register_write_script_sequencer #(
	parameter int SCRIPT_DEPTH  = 64,
	parameter int EFFECT_COUNT  = 16,
	parameter int CHANNEL_COUNT = 2,
	parameter int MAX_BURST     = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_stall,
	input  rwss_pkg::in_t        cmd,
	output logic                 wr_valid,
	input  logic                 wr_stall,
	output rwss_pkg::out_t       wr
);

	localparam int AW  = (SCRIPT_DEPTH > 1) ? $clog2(SCRIPT_DEPTH) : 1;
	localparam int EW  = (EFFECT_COUNT > 1) ? $clog2(EFFECT_COUNT) : 1;
	localparam int CHW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int RCW = ((AW > 6) ? AW : 6) + 1;
	localparam int ECW = ((EW > 4) ? EW : 4) + 1;
	localparam int CCW = CHW + 1;
	localparam int BW  = $clog2(MAX_BURST + 1);
	localparam int NW  = rwss_pkg::N_W;

	rwss_pkg::state_t state_q, state_d;

	logic [CHW-1:0] ch_q;
	logic [NW-1:0]  n_q;
	logic [BW-1:0]  burst_q;
	logic           first_q;
	logic [CHW-1:0] play_ch_q;
	logic [AW-1:0]  play_start_q;

	logic           busy_q   [CHANNEL_COUNT];
	logic [AW-1:0]  cursor_q [CHANNEL_COUNT];
	logic [7:0]     count_q  [CHANNEL_COUNT];

	logic           pend_v_q;
	rwss_pkg::out_t pend_q;
	logic           out_v_q;
	rwss_pkg::out_t out_q;

	logic           row_we, row_re, eff_we, eff_re;
	logic [AW-1:0]  row_waddr, row_raddr;
	logic [EW-1:0]  eff_addr;
	logic [23:0]    row_rd;
	logic [6:0]     eff_rd;

	logic           cmd_acc;
	logic [RCW-1:0] row_idx_ext, eff_start_ext;
	logic [ECW-1:0] eid_ext;
	logic           row_idx_ok, eid_ok, eff_ch_ok, eff_start_ok;
	logic           cur_busy;
	logic [AW-1:0]  cur_row;
	logic [7:0]     cur_cnt;
	logic [AW:0]    next_row;
	logic           next_past, last_ch, can_push, emit_ok, n_full, burst_full;
	logic [7:0]     rd_delay;
	logic           stop_end, stop_wait, stop_cap, do_emit, emit_fire, flush_fire, push;
	logic           tick_skip, burst_done, next_ch;

	logic           ch_we;
	logic [CHW-1:0] ch_sel;
	logic           busy_d;
	logic [AW-1:0]  cursor_d;
	logic [7:0]     count_d;

	rwss_ram #(.WIDTH(24), .DEPTH(SCRIPT_DEPTH), .AW(AW)) u_rows (
		.clk   (clk),
		.we    (row_we),
		.waddr (row_waddr),
		.wdata ({cmd.row_delay, cmd.row_register, cmd.row_data}),
		.re    (row_re),
		.raddr (row_raddr),
		.rdata (row_rd)
	);

	rwss_ram #(.WIDTH(7), .DEPTH(EFFECT_COUNT), .AW(EW)) u_effects (
		.clk   (clk),
		.we    (eff_we),
		.waddr (eff_addr),
		.wdata ({cmd.effect_start, cmd.effect_channel}),
		.re    (eff_re),
		.raddr (eff_addr),
		.rdata (eff_rd)
	);

	assign cmd_stall = (state_q != rwss_pkg::ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;

	assign row_idx_ext   = RCW'(cmd.row_index);
	assign eff_start_ext = RCW'(eff_rd[6:1]);
	assign eid_ext       = ECW'(cmd.effect_id);
	assign row_idx_ok    = row_idx_ext < RCW'(SCRIPT_DEPTH);
	assign eid_ok        = eid_ext < ECW'(EFFECT_COUNT);
	assign eff_ch_ok     = CCW'(eff_rd[0]) < CCW'(CHANNEL_COUNT);
	assign eff_start_ok  = eff_start_ext < RCW'(SCRIPT_DEPTH);

	assign row_we    = cmd_acc && (cmd.mode == rwss_pkg::MODE_ROW) && row_idx_ok;
	assign row_waddr = AW'(row_idx_ext);
	assign eff_we    = cmd_acc && (cmd.mode == rwss_pkg::MODE_EFF) && eid_ok;
	assign eff_re    = cmd_acc && (cmd.mode == rwss_pkg::MODE_PLAY) && eid_ok;
	assign eff_addr  = EW'(eid_ext);

	assign cur_busy   = busy_q[ch_q];
	assign cur_row    = cursor_q[ch_q];
	assign cur_cnt    = count_q[ch_q];
	assign next_row   = {1'b0, cur_row} + (AW+1)'(1);
	assign next_past  = next_row >= (AW+1)'(SCRIPT_DEPTH);
	assign last_ch    = ch_q == CHW'(CHANNEL_COUNT - 1);
	assign can_push   = !out_v_q || !wr_stall;
	assign emit_ok    = !pend_v_q || can_push;
	assign n_full     = n_q >= NW'(rwss_pkg::MAX_OUT);
	assign burst_full = burst_q >= BW'(MAX_BURST);
	assign rd_delay   = row_rd[23:16];

	assign stop_end  = !first_q && (rd_delay == rwss_pkg::END_MARK);
	assign stop_wait = !first_q && (rd_delay != 8'd0) && (rd_delay != rwss_pkg::END_MARK);
	assign stop_cap  = !first_q && (rd_delay == 8'd0) && (burst_full || n_full);
	assign do_emit   = !(stop_end || stop_wait || stop_cap);

	assign emit_fire  = (state_q == rwss_pkg::ST_BURST) && do_emit && emit_ok;
	assign flush_fire = (state_q == rwss_pkg::ST_TICK_END) && pend_v_q && can_push;
	assign push       = (emit_fire && pend_v_q) || flush_fire;

	assign tick_skip  = !cur_busy || (cur_cnt != 8'd0) || n_full;
	assign burst_done = !do_emit || (emit_fire && next_past);
	assign next_ch    = ((state_q == rwss_pkg::ST_TICK_CH) && tick_skip) ||
		((state_q == rwss_pkg::ST_BURST) && burst_done);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rwss_pkg::ST_IDLE: begin
				if (cmd_acc && (cmd.mode == rwss_pkg::MODE_TICK)) begin
					state_d = rwss_pkg::ST_TICK_CH;
				end else if (eff_re) begin
					state_d = rwss_pkg::ST_PLAY_EFF;
				end
			end
			rwss_pkg::ST_PLAY_EFF: begin
				if (eff_ch_ok && eff_start_ok) begin
					state_d = rwss_pkg::ST_PLAY_ROW;
				end else begin
					state_d = rwss_pkg::ST_IDLE;
				end
			end
			rwss_pkg::ST_PLAY_ROW: begin
				state_d = rwss_pkg::ST_IDLE;
			end
			rwss_pkg::ST_TICK_CH: begin
				if (!tick_skip) begin
					state_d = rwss_pkg::ST_BURST;
				end else if (last_ch) begin
					state_d = rwss_pkg::ST_TICK_END;
				end
			end
			rwss_pkg::ST_BURST: begin
				if (burst_done) begin
					state_d = last_ch ? rwss_pkg::ST_TICK_END : rwss_pkg::ST_TICK_CH;
				end
			end
			rwss_pkg::ST_TICK_END: begin
				if (!pend_v_q || can_push) begin
					state_d = rwss_pkg::ST_IDLE;
				end
			end
			default: state_d = rwss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ch_we     = 1'b0;
		ch_sel    = ch_q;
		busy_d    = cur_busy;
		cursor_d  = cur_row;
		count_d   = cur_cnt;
		row_re    = 1'b0;
		row_raddr = cur_row;
		unique case (state_q)
			rwss_pkg::ST_PLAY_EFF: begin
				if (eff_ch_ok) begin
					ch_sel = CHW'(eff_rd[0]);
					if (eff_start_ok) begin
						row_re    = 1'b1;
						row_raddr = AW'(eff_start_ext);
					end else begin
						ch_we    = 1'b1;
						busy_d   = 1'b0;
						cursor_d = AW'(eff_start_ext);
						count_d  = 8'd0;
					end
				end
			end
			rwss_pkg::ST_PLAY_ROW: begin
				ch_we    = 1'b1;
				ch_sel   = play_ch_q;
				cursor_d = play_start_q;
				if (rd_delay == rwss_pkg::END_MARK) begin
					busy_d  = 1'b0;
					count_d = 8'd0;
				end else begin
					busy_d  = 1'b1;
					count_d = rd_delay;
				end
			end
			rwss_pkg::ST_TICK_CH: begin
				if (cur_busy && (cur_cnt != 8'd0)) begin
					ch_we   = 1'b1;
					count_d = cur_cnt - 8'd1;
				end else if (!tick_skip) begin
					row_re = 1'b1;
				end
			end
			rwss_pkg::ST_BURST: begin
				if (stop_end) begin
					ch_we   = 1'b1;
					busy_d  = 1'b0;
					count_d = 8'd0;
				end else if (stop_wait) begin
					ch_we   = 1'b1;
					count_d = rd_delay;
				end else if (emit_fire) begin
					ch_we    = 1'b1;
					cursor_d = next_row[AW-1:0];
					if (next_past) begin
						busy_d  = 1'b0;
						count_d = 8'd0;
					end else begin
						row_re    = 1'b1;
						row_raddr = next_row[AW-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rwss_pkg::ST_IDLE;
			ch_q     <= '0;
			n_q      <= '0;
			burst_q  <= '0;
			first_q  <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				busy_q[i]   <= 1'b0;
				cursor_q[i] <= '0;
				count_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cmd_acc && (cmd.mode == rwss_pkg::MODE_TICK)) begin
				ch_q <= '0;
				n_q  <= '0;
			end else if (next_ch) begin
				ch_q <= ch_q + CHW'(1);
			end
			if ((state_q == rwss_pkg::ST_TICK_CH) && !tick_skip) begin
				burst_q <= '0;
				first_q <= 1'b1;
			end else if (emit_fire) begin
				burst_q <= burst_q + BW'(1);
				n_q     <= n_q + NW'(1);
				first_q <= 1'b0;
			end
			if (ch_we) begin
				busy_q[ch_sel]   <= busy_d;
				cursor_q[ch_sel] <= cursor_d;
				count_q[ch_sel]  <= count_d;
			end
			if (emit_fire) begin
				pend_v_q <= 1'b1;
			end else if (flush_fire) begin
				pend_v_q <= 1'b0;
			end
			out_v_q <= push || (out_v_q && wr_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rwss_pkg::ST_PLAY_EFF) begin
			play_ch_q    <= CHW'(eff_rd[0]);
			play_start_q <= AW'(eff_start_ext);
		end
		if (emit_fire) begin
			pend_q.out_channel   <= ch_q[0];
			pend_q.write_address <= row_rd[15:8];
			pend_q.write_data    <= row_rd[7:0];
			pend_q.last_write    <= 1'b0;
		end
		if (push) begin
			out_q.out_channel   <= pend_q.out_channel;
			out_q.write_address <= pend_q.write_address;
			out_q.write_data    <= pend_q.write_data;
			out_q.last_write    <= flush_fire;
		end
	end

	assign wr_valid = out_v_q;
	assign wr       = out_q;

endmodule

@@ src/rwss_ram.sv @@
module rwss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ tb/testbench.sv @@
module testbench;

	import rwss_pkg::*;

	localparam int ROWS = 64;
	localparam int EFFECTS = 16;
	localparam int CHANNELS = 2;
	localparam int BURST_CAP = 32;
	localparam int TICK_CAP = 64;
	localparam int ITEM_TARGET = 470;
	localparam int CALM_ITEMS = 50;
	localparam int SETTLE_CYCLES = 150;
	localparam int CYCLE_LIMIT = 2_000_000;

	class write_scoreboard;
		out_t expected_writes[$];
		bit [7:0] row_wait[ROWS];
		bit [7:0] row_addr[ROWS];
		bit [7:0] row_value[ROWS];
		bit [5:0] effect_first[EFFECTS];
		bit effect_chan[EFFECTS];
		bit active[CHANNELS];
		int row_ptr[CHANNELS];
		bit [7:0] wait_frames[CHANNELS];
		int errors;
		int ticks;
		int plays;
		int loads;
		int writes_checked;
		int longest_tick;

		function void launch_effect(int chan, int first);
			row_ptr[chan] = first;
			wait_frames[chan] = 8'd0;
			if (first >= ROWS || row_wait[first] == END_MARK) begin
				active[chan] = 1'b0;
			end else begin
				active[chan] = 1'b1;
				wait_frames[chan] = row_wait[first];
			end
		endfunction

		function void play_frame();
			int produced;
			int burst;
			bit have_held;
			out_t held;
			out_t fresh;
			produced = 0;
			have_held = 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				burst = 0;
				if (!active[c])
					continue;
				if (wait_frames[c] != 8'd0) begin
					wait_frames[c]--;
					continue;
				end
				while (burst < BURST_CAP && produced < TICK_CAP) begin
					if (row_ptr[c] >= ROWS) begin
						active[c] = 1'b0;
						break;
					end
					fresh.out_channel = c[0];
					fresh.write_address = row_addr[row_ptr[c]];
					fresh.write_data = row_value[row_ptr[c]];
					fresh.last_write = 1'b0;
					if (have_held)
						expected_writes.push_back(held);
					held = fresh;
					have_held = 1'b1;
					produced++;
					burst++;
					row_ptr[c]++;
					if (row_ptr[c] >= ROWS || row_wait[row_ptr[c]] == END_MARK) begin
						active[c] = 1'b0;
						wait_frames[c] = 8'd0;
						break;
					end
					wait_frames[c] = row_wait[row_ptr[c]];
					if (wait_frames[c] != 8'd0)
						break;
				end
			end
			if (have_held) begin
				held.last_write = 1'b1;
				expected_writes.push_back(held);
			end
			if (produced > longest_tick)
				longest_tick = produced;
		endfunction

		function void apply_command(in_t item);
			case (item.mode)
				MODE_ROW: begin
					row_wait[item.row_index] = item.row_delay;
					row_addr[item.row_index] = item.row_register;
					row_value[item.row_index] = item.row_data;
					loads++;
				end
				MODE_EFF: begin
					effect_first[item.effect_id] = item.effect_start;
					effect_chan[item.effect_id] = item.effect_channel;
					loads++;
				end
				MODE_PLAY: begin
					launch_effect(effect_chan[item.effect_id], effect_first[item.effect_id]);
					plays++;
				end
				default: begin
					play_frame();
					ticks++;
				end
			endcase
		endfunction

		function void check_write(out_t got);
			out_t want;
			if (expected_writes.size() == 0) begin
				$error("register write with nothing expected: %h", got);
				errors++;
				return;
			end
			want = expected_writes.pop_front();
			writes_checked++;
			if (got.out_channel !== want.out_channel) begin
				$error("out_channel expected %0d got %0d", want.out_channel, got.out_channel);
				errors++;
			end
			if (got.write_address !== want.write_address) begin
				$error("write_address expected %0h got %0h", want.write_address,
					got.write_address);
				errors++;
			end
			if (got.write_data !== want.write_data) begin
				$error("write_data expected %0h got %0h", want.write_data, got.write_data);
				errors++;
			end
			if (got.last_write !== want.last_write) begin
				$error("last_write expected %0d got %0d", want.last_write, got.last_write);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	in_t cmd = '0;
	logic wr_valid;
	logic wr_stall = 1'b0;
	out_t wr;

	write_scoreboard sb = new();
	bit idle_on = 1'b1;
	int stall_left = 0;
	int items_sent = 0;
	int cycle_count = 0;

	register_write_script_sequencer #(
		.SCRIPT_DEPTH(ROWS),
		.EFFECT_COUNT(EFFECTS),
		.CHANNEL_COUNT(CHANNELS),
		.MAX_BURST(BURST_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.wr_valid(wr_valid),
		.wr_stall(wr_stall),
		.wr(wr)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (wr_valid && !wr_stall)
				sb.check_write(wr);
			if (cmd_valid && !cmd_stall)
				sb.apply_command(cmd);
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
			stall_left = $urandom_range(1, 10);
		if (stall_left != 0) begin
			wr_stall <= 1'b1;
			stall_left--;
		end else begin
			wr_stall <= 1'b0;
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	function automatic in_t random_cmd();
		in_t item;
		item = $bits(in_t)'({$urandom(), $urandom()});
		return item;
	endfunction

	function automatic logic [7:0] pick_delay();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 8'd0;
		if (roll < 75)
			return 8'($urandom_range(1, 3));
		if (roll < 88)
			return END_MARK;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_cmd(input in_t item);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= item;
		do
			@(posedge clk);
		while (cmd_stall);
		items_sent++;
	endtask

	task automatic send_tick();
		in_t item;
		item = random_cmd();
		item.mode = MODE_TICK;
		send_cmd(item);
	endtask

	task automatic send_play(input logic [3:0] id);
		in_t item;
		item = random_cmd();
		item.mode = MODE_PLAY;
		item.effect_id = id;
		send_cmd(item);
	endtask

	task automatic send_row(input logic [5:0] idx, input logic [7:0] dly,
		input logic [7:0] reg_lo, input logic [7:0] val);
		in_t item;
		item = random_cmd();
		item.mode = MODE_ROW;
		item.row_index = idx;
		item.row_delay = dly;
		item.row_register = reg_lo;
		item.row_data = val;
		send_cmd(item);
	endtask

	task automatic send_effect(input logic [3:0] id, input logic [5:0] first,
		input logic chan);
		in_t item;
		item = random_cmd();
		item.mode = MODE_EFF;
		item.effect_id = id;
		item.effect_start = first;
		item.effect_channel = chan;
		send_cmd(item);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (sb.expected_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int pick;
		int first;
		int len;
		int id;
		int next_switch;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Only rows and effect entries written so far are ever reached here.
		send_tick();
		send_row(6'd0, 8'd0, 8'h00, 8'h00);
		send_row(6'd1, 8'd0, 8'hFF, 8'hFF);
		send_row(6'd2, 8'd2, 8'h12, 8'h34);
		send_row(6'd3, END_MARK, 8'hAA, 8'h55);
		send_effect(4'd0, 6'd0, 1'b0);
		send_effect(4'd15, 6'd3, 1'b1);
		send_play(4'd0);
		send_play(4'd15);
		repeat (4) send_tick();
		send_row(6'd63, 8'd0, 8'h63, 8'h3F);
		send_effect(4'd1, 6'd63, 1'b1);
		send_play(4'd1);
		send_tick();
		send_play(4'd0);
		send_tick();
		send_play(4'd0);
		send_tick();
		drain();

		for (int r = 0; r < ROWS; r++)
			send_row(6'(r), pick_delay(), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
		for (int e = 0; e < EFFECTS; e++)
			send_effect(4'(e), 6'($urandom_range(0, ROWS - 1)), 1'($urandom_range(0, 1)));

		next_switch = items_sent;
		while (items_sent < ITEM_TARGET) begin
			if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
				idle_on = 1'b0;
			end else if (items_sent >= next_switch) begin
				idle_on = $urandom_range(0, 3) != 0;
				next_switch = items_sent + 30;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_tick();
			end else if (pick < 70) begin
				send_play(4'($urandom_range(0, EFFECTS - 1)));
			end else if (pick < 78) begin
				send_row(6'($urandom_range(0, ROWS - 1)), pick_delay(),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end else if (pick < 83) begin
				send_effect(4'($urandom_range(0, EFFECTS - 1)),
					6'($urandom_range(0, ROWS - 1)), 1'($urandom_range(0, 1)));
			end else begin
				// A fresh script: rows, an end marker unless it reaches the last row, its effect entry, a play, then ticks.
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 6);
				first = $urandom_range(0, ROWS - len);
				id = $urandom_range(0, EFFECTS - 1);
				for (int i = 0; i < len; i++)
					send_row(6'(first + i),
						(i == 0) ? 8'($urandom_range(0, 2)) :
						(len < 10 && $urandom_range(0, 3) == 0) ? 8'd1 : 8'd0,
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				if (first + len < ROWS)
					send_row(6'(first + len), END_MARK, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				send_effect(4'(id), 6'(first), 1'($urandom_range(0, 1)));
				send_play(4'(id));
				repeat ($urandom_range(1, 6)) send_tick();
			end
		end
		drain();

		$display("Sent %0d items: %0d ticks, %0d plays, %0d loads.", items_sent, sb.ticks,
			sb.plays, sb.loads);
		$display("Checked %0d register writes; the busiest tick gave %0d, with %0d errors.",
			sb.writes_checked, sb.longest_tick, sb.errors);
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
